@@ hdl/ltc_pkg.sv @@
package ltc_pkg;

  localparam int BIN_W = 48;
  localparam int CNT_W = 32;
  localparam int BINS_W = 2 * BIN_W + 2 * CNT_W;
  localparam int PE_STAGES = 8;
  localparam int LAG_SEL_W = 6;
  localparam int MAX_LAG_W = 7;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  localparam logic [0:0] REG_MAX_LAG = 1'd0;
  localparam logic [0:0] REG_TORSION = 1'd1;

  localparam logic [BIN_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [BIN_W-1:0] ACC_MIN = 48'h8000_0000_0000;

  // quarter-wave cosine polynomial, Q30
  localparam logic [19:0] COS_C4 = 20'd987048;
  localparam logic [24:0] COS_C3 = 25'd22401993;
  localparam logic [28:0] COS_C2 = 29'd272375560;
  localparam logic [30:0] COS_C1 = 31'd1324675879;

  typedef struct packed {
    logic is_elem;
    logic first;
    logic tan_en;
    logic tw_en;
    logic clear_win;
    logic shift_win;
  } ctrl_t;

endpackage

@@ hdl/ltc_in_if.sv @@
interface ltc_in_if #(
  parameter int COMPONENT_BITS = 16,
  parameter int ANGLE_BITS = 16
);
  logic valid;
  logic ready;
  logic [1:0] command;
  logic signed [COMPONENT_BITS-1:0] tang_x;
  logic signed [COMPONENT_BITS-1:0] tang_y;
  logic signed [COMPONENT_BITS-1:0] tang_z;
  logic [ANGLE_BITS-1:0] twist_angle;
  logic twist_valid;
  logic [5:0] lag_select;

  modport source (output valid, command, tang_x, tang_y, tang_z, twist_angle,
                  twist_valid, lag_select, input ready);
  modport sink (input valid, command, tang_x, tang_y, tang_z, twist_angle,
                twist_valid, lag_select, output ready);
endinterface

@@ hdl/ltc_out_if.sv @@
interface ltc_out_if;
  logic valid;
  logic ready;
  logic signed [47:0] tangent_sum;
  logic [31:0] tangent_count;
  logic signed [47:0] twist_sum;
  logic [31:0] twist_count;
  logic [5:0] lag_echo;

  modport source (output valid, tangent_sum, tangent_count, twist_sum, twist_count,
                  lag_echo, input ready);
  modport sink (input valid, tangent_sum, tangent_count, twist_sum, twist_count,
                lag_echo, output ready);
endinterface

@@ hdl/lagged_tangent_twist_correlator.sv @@
// Lagged tangent/twist correlator. Every command (push, start, read) takes one
// sweep and a return to the idle state; a read also passes through an emit
// state that loads the output register, and waits there while an earlier
// result is still held: all per-lag state lives in a ring of cells that
// rotates once past a single shared 8-stage unit (three multipliers for the
// dot product, a four-multiply Horner cosine), one lag per cycle. The input
// channel is ready only between sweeps. A read result sits in an output
// register until transferred; the block goes on taking commands while it is
// held. Command 3 is dropped at once. Bins are held in reset-cleared
// flip-flops, so no clearing pass is needed.
module lagged_tangent_twist_correlator import ltc_pkg::*; #(
  parameter int MAX_LAG_LIMIT = 64,
  parameter int COMPONENT_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  ltc_in_if.sink               in_ch,
  ltc_out_if.source            out_ch,
  input  logic                 cfg_write,
  input  logic [0:0]           cfg_index,
  input  logic [MAX_LAG_W-1:0] cfg_data
);
  localparam int N = MAX_LAG_LIMIT;
  localparam int CB = COMPONENT_BITS;
  localparam int AB = ANGLE_BITS;
  localparam int EW = 3 * CB + AB + BINS_W;
  localparam int T = N + PE_STAGES;
  localparam int XW = ($clog2(T + 1) > MAX_LAG_W) ? $clog2(T + 1) : MAX_LAG_W;
  localparam int FW = $clog2(N + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [XW-1:0] cnt;
  logic [MAX_LAG_W-1:0] max_lag;
  logic torsion;
  logic [FW-1:0] filled;
  logic [AB-1:0] running;

  // per-sweep command latch
  logic [1:0] op;
  logic twv;
  logic tw_on;
  logic signed [CB-1:0] nt_x, nt_y, nt_z;
  logic [AB-1:0] newp;
  logic [XW-1:0] lim_tan, lim_tw;
  logic [LAG_SEL_W-1:0] sel;

  logic signed [BIN_W-1:0] h_tb, h_wb;
  logic [CNT_W-1:0] h_tc, h_wc;

  logic [EW-1:0] chain [0:N];
  logic run;
  ctrl_t ctrl;
  logic accept;
  logic [XW-1:0] lag_eff, fill_x, fill1_x, avail_x;
  logic [AB-1:0] newp_in;

  assign run = (state == ST_RUN);
  assign in_ch.ready = (state == ST_IDLE);
  assign accept = in_ch.valid & in_ch.ready;

  // effective lag limits for a push
  assign lag_eff = (XW'(max_lag) > XW'(N)) ? XW'(N) : XW'(max_lag);
  assign fill_x = XW'(filled);
  assign fill1_x = XW'(filled) + 1'b1;
  assign avail_x = (fill1_x > XW'(N)) ? XW'(N) : fill1_x;
  assign newp_in = running + in_ch.twist_angle;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      max_lag <= MAX_LAG_W'(64);
      torsion <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_LAG: max_lag <= cfg_data;
        REG_TORSION: torsion <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      filled <= '0;
      running <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != ST_EMIT) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && in_ch.command != CMD_RSVD) begin
            state <= ST_RUN;
            cnt <= '0;
            if (in_ch.command == CMD_PUSH && in_ch.twist_valid) begin
              running <= newp_in;
              if (filled != FW'(N)) begin
                filled <= filled + 1'b1;
              end
            end else if (in_ch.command != CMD_READ) begin
              running <= '0;
              filled <= '0;
            end
          end
        end
        ST_RUN: begin
          if (cnt == XW'(T - 1)) begin
            cnt <= '0;
            state <= (op == CMD_READ) ? ST_EMIT : ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_EMIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // command latch, read capture, output register
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= in_ch.command;
      twv <= in_ch.twist_valid;
      tw_on <= torsion;
      nt_x <= in_ch.tang_x;
      nt_y <= in_ch.tang_y;
      nt_z <= in_ch.tang_z;
      newp <= newp_in;
      lim_tan <= (fill_x < lag_eff) ? fill_x : lag_eff;
      lim_tw <= (avail_x < lag_eff) ? avail_x : lag_eff;
      sel <= in_ch.lag_select;
      // out-of-range reads return zeros
      h_tb <= '0;
      h_tc <= '0;
      h_wb <= '0;
      h_wc <= '0;
    end
    if (run && ctrl.is_elem && op == CMD_READ && cnt == XW'(sel)) begin
      h_tb <= chain[0][BINS_W-1 -: BIN_W];
      h_tc <= chain[0][2*CNT_W+BIN_W-1 -: CNT_W];
      h_wb <= chain[0][CNT_W+BIN_W-1 -: BIN_W];
      h_wc <= chain[0][CNT_W-1:0];
    end
    if (state == ST_EMIT && (!out_ch.valid || out_ch.ready)) begin
      out_ch.tangent_sum <= h_tb;
      out_ch.tangent_count <= h_tc;
      out_ch.twist_sum <= h_wb;
      out_ch.twist_count <= h_wc;
      out_ch.lag_echo <= sel;
    end
  end

  // lag index at the unit input is the sweep count
  always_comb begin
    ctrl.is_elem = (cnt < XW'(N));
    ctrl.first = (cnt == '0);
    ctrl.tan_en = (op == CMD_PUSH) && (cnt < lim_tan);
    ctrl.tw_en = (op == CMD_PUSH) && twv && tw_on && (cnt < lim_tw);
    ctrl.clear_win = (op == CMD_START) || (op == CMD_PUSH && !twv);
    ctrl.shift_win = (op == CMD_PUSH) && twv;
  end

  // ring: cell k takes from cell k+1, the unit output feeds the far end
  for (genvar k = 0; k < N; k++) begin : g_cell
    ltc_cell #(.W(EW)) u_cell (
      .clk(clk), .rst(rst), .run(run), .d(chain[k+1]), .q(chain[k])
    );
  end

  ltc_pe #(.CB(CB), .AB(AB)) u_pe (
    .clk(clk), .rst(rst), .run(run), .ctrl(ctrl),
    .nt_x(nt_x), .nt_y(nt_y), .nt_z(nt_z), .newp(newp),
    .elem_in(chain[0]), .elem_out(chain[N])
  );

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ch.ready) else $error("ready during sweep");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_RUN |-> cnt == '0) else $error("sweep count not parked");
  a_filled: assert property (@(posedge clk) disable iff (rst)
    filled <= FW'(N)) else $error("fill count overflow");
  a_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && !out_ch.valid |=> out_ch.valid && state == ST_IDLE)
    else $error("read result not loaded");
endmodule

@@ hdl/ltc_cell.sv @@
module ltc_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         run,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (run) begin
      q <= d;
    end
  end
endmodule

@@ hdl/ltc_pe.sv @@
module ltc_pe import ltc_pkg::*; #(
  parameter int CB = 16,
  parameter int AB = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      run,
  input  ctrl_t                     ctrl,
  input  logic signed [CB-1:0]      nt_x,
  input  logic signed [CB-1:0]      nt_y,
  input  logic signed [CB-1:0]      nt_z,
  input  logic [AB-1:0]             newp,
  input  logic [3*CB+AB+BINS_W-1:0] elem_in,
  output logic [3*CB+AB+BINS_W-1:0] elem_out
);
  localparam int WW = 3 * CB + AB;
  localparam int PW = 2 * CB;
  localparam int DW = 2 * CB + 2;
  localparam int SW = (DW + 1 > BIN_W + 1) ? DW + 1 : BIN_W + 1;
  localparam int SH_R = (AB >= 16) ? AB - 16 : 0;
  localparam int SH_L = (AB < 16) ? 16 - AB : 0;

  // window part and bins, per stage
  logic [WW-1:0] win_s [1:PE_STAGES];
  logic signed [BIN_W-1:0] tb_s [1:PE_STAGES];
  logic [CNT_W-1:0] tc_s [1:PE_STAGES];
  logic signed [BIN_W-1:0] wb_s [1:PE_STAGES];
  logic [CNT_W-1:0] wc_s [1:PE_STAGES];
  logic tan_s [1:PE_STAGES];
  logic tw_s [1:PE_STAGES];

  logic [WW-1:0] carry;
  logic [WW-1:0] win_old, win_new;
  logic signed [CB-1:0] ox, oy, oz;
  logic [AB-1:0] oang, w;
  logic [15:0] a16;
  logic [14:0] s_in;

  logic signed [PW-1:0] px1, py1, pz1;
  logic [1:0] q_s [1:7];
  logic [14:0] s1;
  logic signed [DW-1:0] d2;
  logic [28:0] u_s [2:5];
  logic [24:0] p1;
  logic [28:0] p2;
  logic [30:0] p3;
  logic [31:0] t6;
  logic signed [15:0] cos7;

  logic [48:0] m3;
  logic [53:0] m4;
  logic [57:0] m5;
  logic [59:0] m6;
  logic signed [SW-1:0] tsum;
  logic signed [BIN_W:0] wsum;
  logic signed [BIN_W-1:0] tb_sat, wb_sat;
  logic [30:0] c7;
  logic [16:0] v7;
  logic [14:0] v7c;

  assign win_old = elem_in[BINS_W +: WW];
  assign ox = win_old[WW-1 -: CB];
  assign oy = win_old[WW-1-CB -: CB];
  assign oz = win_old[WW-1-2*CB -: CB];
  assign oang = win_old[AB-1:0];

  always_comb begin
    win_new = win_old;
    if (ctrl.is_elem) begin
      if (ctrl.clear_win) begin
        win_new = '0;
      end else if (ctrl.shift_win) begin
        win_new = ctrl.first ? {nt_x, nt_y, nt_z, newp} : carry;
      end
    end
  end

  assign w = newp - oang;
  assign a16 = 16'((32'(w) << SH_L) >> SH_R);
  assign s_in = a16[14] ? 15'(15'd16384 - {1'b0, a16[13:0]}) : {1'b0, a16[13:0]};

  assign m3 = COS_C4 * u_s[2];
  assign m4 = p1 * u_s[3];
  assign m5 = p2 * u_s[4];
  assign m6 = p3 * u_s[5];

  assign tsum = SW'(tb_s[2]) + SW'(d2);
  always_comb begin
    if (tsum > $signed({{(SW-BIN_W){1'b0}}, ACC_MAX})) begin
      tb_sat = ACC_MAX;
    end else if (tsum < $signed({{(SW-BIN_W){1'b1}}, ACC_MIN})) begin
      tb_sat = ACC_MIN;
    end else begin
      tb_sat = tsum[BIN_W-1:0];
    end
  end

  assign c7 = (t6 >= 32'h4000_0000) ? 31'd0 : 31'(32'h4000_0000 - t6);
  assign v7 = 17'((32'(c7) + 32'd16384) >> 15);
  assign v7c = (v7 > 17'd32767) ? 15'h7FFF : v7[14:0];

  assign wsum = (BIN_W + 1)'(wb_s[7]) + (BIN_W + 1)'(cos7);
  always_comb begin
    if (wsum > $signed({1'b0, ACC_MAX})) begin
      wb_sat = ACC_MAX;
    end else if (wsum < $signed({1'b1, ACC_MIN})) begin
      wb_sat = ACC_MIN;
    end else begin
      wb_sat = wsum[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= PE_STAGES; i++) begin
        tan_s[i] <= 1'b0;
        tw_s[i] <= 1'b0;
      end
    end else if (run) begin
      tan_s[1] <= ctrl.is_elem & ctrl.tan_en;
      tw_s[1] <= ctrl.is_elem & ctrl.tw_en;
      for (int i = 2; i <= PE_STAGES; i++) begin
        tan_s[i] <= tan_s[i-1];
        tw_s[i] <= tw_s[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      if (ctrl.is_elem) begin
        carry <= win_old;
      end
      // entry stage
      win_s[1] <= win_new;
      tb_s[1] <= elem_in[BINS_W-1 -: BIN_W];
      tc_s[1] <= elem_in[2*CNT_W+BIN_W-1 -: CNT_W];
      wb_s[1] <= elem_in[CNT_W+BIN_W-1 -: BIN_W];
      wc_s[1] <= elem_in[CNT_W-1:0];
      px1 <= nt_x * ox;
      py1 <= nt_y * oy;
      pz1 <= nt_z * oz;
      q_s[1] <= a16[15:14];
      s1 <= s_in;
      // plain pass-through except where a bin is updated below
      for (int i = 2; i <= PE_STAGES; i++) begin
        win_s[i] <= win_s[i-1];
        if (!(i == 3 && tan_s[2])) begin
          tb_s[i] <= tb_s[i-1];
          tc_s[i] <= tc_s[i-1];
        end
        if (!(i == PE_STAGES && tw_s[7])) begin
          wb_s[i] <= wb_s[i-1];
          wc_s[i] <= wc_s[i-1];
        end
      end
      for (int i = 2; i <= 7; i++) begin
        q_s[i] <= q_s[i-1];
      end
      for (int i = 3; i <= 5; i++) begin
        u_s[i] <= u_s[i-1];
      end
      // dot product and s^2
      d2 <= DW'(px1) + DW'(py1) + DW'(pz1);
      u_s[2] <= 29'(s1) * 29'(s1);
      // tangent bin
      if (tan_s[2]) begin
        tb_s[3] <= tb_sat;
        tc_s[3] <= (tc_s[2] == '1) ? tc_s[2] : tc_s[2] + 1'b1;
      end
      // Horner chain, one multiply per stage
      p1 <= COS_C3 - 25'(m3 >> 28);
      p2 <= COS_C2 - 29'(m4 >> 28);
      p3 <= COS_C1 - 31'(m5 >> 28);
      t6 <= 32'(m6 >> 28);
      cos7 <= (q_s[6] == 2'd1 || q_s[6] == 2'd2) ? -$signed({1'b0, v7c})
                                                  : $signed({1'b0, v7c});
      // twist bin
      if (tw_s[7]) begin
        wb_s[8] <= wb_sat;
        wc_s[8] <= (wc_s[7] == '1) ? wc_s[7] : wc_s[7] + 1'b1;
      end
    end
  end

  assign elem_out = {win_s[PE_STAGES], tb_s[PE_STAGES], tc_s[PE_STAGES],
                     wb_s[PE_STAGES], wc_s[PE_STAGES]};
endmodule

@@ verif/tb.sv @@
module tb;
  import ltc_pkg::*;

  // one input command as driven onto the input channel
  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
    logic [15:0]        ang;
    logic               tvld;
    logic [5:0]         sel;
  } pair_cmd_t;

  // one bin set as returned by a read
  typedef struct {
    logic [47:0] tan_sum;
    logic [31:0] tan_cnt;
    logic [47:0] tw_sum;
    logic [31:0] tw_cnt;
    logic [5:0]  lag;
  } bin_set_t;

  localparam int LAGS = 64;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -64'sh0000_8000_0000_0000;
  localparam int QUIET_CYCLES = 90;   // one full sweep plus margin
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = REG_MAX_LAG;
  logic [MAX_LAG_W-1:0] cfg_data = '0;

  ltc_in_if #(.COMPONENT_BITS(16), .ANGLE_BITS(16)) in_ch ();
  ltc_out_if out_ch ();

  lagged_tangent_twist_correlator DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: chain windows, bins and the config copy
  // ---------------------------------------------------------------------
  logic signed [15:0] win_x [LAGS];
  logic signed [15:0] win_y [LAGS];
  logic signed [15:0] win_z [LAGS];
  logic [15:0] prefix_win [LAGS];
  logic [15:0] running_twist;
  int unsigned filled;
  longint tan_bins [LAGS];
  int unsigned tan_cnts [LAGS];
  longint tw_bins [LAGS];
  int unsigned tw_cnts [LAGS];
  int unsigned lag_reg;
  logic torsion_on;

  pair_cmd_t stim_items [$];
  bin_set_t pending_reads [$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned errors = 0;
  bit steady = 1'b0;  // 1 = no idling on either side

  function automatic longint sat48(longint acc, longint add);
    longint s;
    s = acc + add;
    if (s > SUM_MAX) return SUM_MAX;
    if (s < SUM_MIN) return SUM_MIN;
    return s;
  endfunction

  function automatic int unsigned bump(int unsigned c);
    return (c == 32'hFFFF_FFFF) ? c : c + 1;
  endfunction

  // quarter-wave folded polynomial cosine, Q1.15 result
  function automatic int twist_cosine(logic [15:0] a);
    logic [1:0] quad;
    longint unsigned s, u, p, t, c, v;
    quad = a[15:14];
    s = quad[0] ? (64'd16384 - a[13:0]) : a[13:0];
    u = s * s;
    p = COS_C4;
    p = COS_C3 - ((p * u) >> 28);
    p = COS_C2 - ((p * u) >> 28);
    p = COS_C1 - ((p * u) >> 28);
    t = (p * u) >> 28;
    c = (t >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - t;
    v = (c + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return (quad == 2'd1 || quad == 2'd2) ? -int'(v) : int'(v);
  endfunction

  function automatic void clear_chain();
    for (int i = 0; i < LAGS; i++) begin
      win_x[i] = '0; win_y[i] = '0; win_z[i] = '0; prefix_win[i] = '0;
    end
    running_twist = '0;
    filled = 0;
  endfunction

  function automatic void reset_model();
    clear_chain();
    for (int i = 0; i < LAGS; i++) begin
      tan_bins[i] = 0; tan_cnts[i] = 0; tw_bins[i] = 0; tw_cnts[i] = 0;
    end
    lag_reg = 64;
    torsion_on = 1'b0;
  endfunction

  // advances the predictor by one accepted command; reads queue a bin set
  function automatic void model_command(pair_cmd_t it);
    int unsigned lag, n, avail;
    longint dot;
    logic [15:0] newp;
    bin_set_t r;
    lag = (lag_reg > LAGS) ? LAGS : lag_reg;
    case (it.cmd)
      CMD_PUSH: begin
        n = (filled < lag) ? filled : lag;
        for (int m = 0; m < n; m++) begin
          dot = longint'(it.tx) * win_x[m] + longint'(it.ty) * win_y[m]
              + longint'(it.tz) * win_z[m];
          tan_bins[m] = sat48(tan_bins[m], dot);
          tan_cnts[m] = bump(tan_cnts[m]);
        end
        if (!it.tvld) begin
          // last pair of the chain: no twist terms, windows drop
          clear_chain();
        end else begin
          newp = running_twist + it.ang;
          avail = (filled + 1 > LAGS) ? LAGS : filled + 1;
          n = (avail < lag) ? avail : lag;
          if (torsion_on) begin
            for (int m = 0; m < n; m++) begin
              tw_bins[m] = sat48(tw_bins[m], twist_cosine(newp - prefix_win[m]));
              tw_cnts[m] = bump(tw_cnts[m]);
            end
          end
          for (int i = LAGS - 1; i > 0; i--) begin
            prefix_win[i] = prefix_win[i-1];
            win_x[i] = win_x[i-1]; win_y[i] = win_y[i-1]; win_z[i] = win_z[i-1];
          end
          prefix_win[0] = newp;
          running_twist = newp;
          win_x[0] = it.tx; win_y[0] = it.ty; win_z[0] = it.tz;
          if (filled < LAGS) filled++;
        end
      end
      CMD_START: clear_chain();
      CMD_READ: begin
        r.tan_sum = tan_bins[it.sel][47:0];
        r.tan_cnt = tan_cnts[it.sel];
        r.tw_sum = tw_bins[it.sel][47:0];
        r.tw_cnt = tw_cnts[it.sel];
        r.lag = it.sel;
        pending_reads.push_back(r);
      end
      default: ;  // command 3 dropped
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(120, 10);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  function automatic pair_cmd_t rand_item(logic [1:0] cmd);
    pair_cmd_t it;
    it.cmd = cmd;
    it.tx = 16'($urandom); it.ty = 16'($urandom); it.tz = 16'($urandom);
    it.ang = 16'($urandom);
    it.tvld = 1'($urandom_range(1));
    it.sel = 6'($urandom_range(63));
    return it;
  endfunction

  function automatic void queue_item(pair_cmd_t it);
    stim_items.push_back(it);
    queued_total++;
  endfunction

  function automatic void queue_push(logic signed [15:0] x, logic signed [15:0] y,
                                     logic signed [15:0] z, logic [15:0] a, logic v);
    pair_cmd_t it;
    it = rand_item(CMD_PUSH);
    it.tx = x; it.ty = y; it.tz = z; it.ang = a; it.tvld = v;
    queue_item(it);
  endfunction

  function automatic void queue_read(logic [5:0] sel);
    pair_cmd_t it;
    it = rand_item(CMD_READ);
    it.sel = sel;
    queue_item(it);
  endfunction

  // well-formed chain: twist_valid high until the closing pair
  function automatic void queue_chain(int len, bit closed);
    pair_cmd_t it;
    for (int i = 0; i < len; i++) begin
      it = rand_item(CMD_PUSH);
      it.tvld = !(closed && i == len - 1);
      if ($urandom_range(9) == 0) begin
        // pinned extremes on a few components
        it.tx = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        it.tz = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
      if ($urandom_range(7) == 0) it.ang = {2'($urandom_range(3)), 14'd0};
      queue_item(it);
    end
  endfunction

  // random phase content; returns after roughly budget commands
  function automatic void queue_phase(int budget);
    int start_cnt, pick;
    start_cnt = queued_total;
    while (queued_total - start_cnt < budget) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        queue_chain(($urandom_range(9) == 0) ? $urandom_range(80, 40)
                                             : $urandom_range(16, 1),
                    $urandom_range(3) != 0);
      end else if (pick < 88) begin
        repeat ($urandom_range(4, 1)) queue_read(6'($urandom_range(63)));
      end else if (pick < 93) begin
        queue_item(rand_item(CMD_START));
      end else if (pick < 96) begin
        queue_item(rand_item(CMD_RSVD));
      end else begin
        queue_item(rand_item(CMD_PUSH));
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: input channel
  // ---------------------------------------------------------------------
  pair_cmd_t cur_item;
  int in_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        model_command(cur_item);
        accepted_total++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the current command
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (stim_items.size() > 0) begin
        cur_item = stim_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.command <= cur_item.cmd;
        in_ch.tang_x <= cur_item.tx;
        in_ch.tang_y <= cur_item.ty;
        in_ch.tang_z <= cur_item.tz;
        in_ch.twist_angle <= cur_item.ang;
        in_ch.twist_valid <= cur_item.tvld;
        in_ch.lag_select <= cur_item.sel;
        in_gap = idle_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: output channel, checks each transfer against the oldest read
  // ---------------------------------------------------------------------
  int out_stall = 0;
  bin_set_t want;

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready && !rst) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected read result, lag_echo %0d", out_ch.lag_echo);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (out_ch.tangent_sum !== want.tan_sum) begin
          $error("tangent_sum exp %0d got %0d", $signed(want.tan_sum), out_ch.tangent_sum);
          errors++;
        end
        if (out_ch.tangent_count !== want.tan_cnt) begin
          $error("tangent_count exp %0d got %0d", want.tan_cnt, out_ch.tangent_count);
          errors++;
        end
        if (out_ch.twist_sum !== want.tw_sum) begin
          $error("twist_sum exp %0d got %0d", $signed(want.tw_sum), out_ch.twist_sum);
          errors++;
        end
        if (out_ch.twist_count !== want.tw_cnt) begin
          $error("twist_count exp %0d got %0d", want.tw_cnt, out_ch.twist_count);
          errors++;
        end
        if (out_ch.lag_echo !== want.lag) begin
          $error("lag_echo exp %0d got %0d", want.lag, out_ch.lag_echo);
          errors++;
        end
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(3) == 0) out_stall = idle_len();
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: cycles without any transfer on either channel
  // ---------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  task automatic wait_drained();
    while (accepted_total != queued_total || pending_reads.size() != 0)
      @(posedge clk);
    // pushes raise no result, so let the last sweep finish
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [MAX_LAG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_MAX_LAG) lag_reg = 32'(val);
    else torsion_on = val[0];
  endtask

  int unsigned lag_plan [8] = '{64, 1, 0, 127, 7, 33, 64, 100};
  bit tors_plan [8] = '{1, 1, 1, 0, 1, 0, 0, 1};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_PUSH;
    in_ch.tang_x = '0; in_ch.tang_y = '0; in_ch.tang_z = '0;
    in_ch.twist_angle = '0; in_ch.twist_valid = 1'b0; in_ch.lag_select = '0;
    out_ch.ready = 1'b0;
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, extremes, every command, chain end and restart
    write_reg(REG_TORSION, MAX_LAG_W'(1));
    queue_push(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0000, 1'b1);
    queue_push(16'sh8000, 16'sh8000, 16'sh8000, 16'h4000, 1'b1);
    queue_push(16'sh8000, 16'sh8000, 16'sh8000, 16'h8000, 1'b1);
    queue_push(16'sh7FFF, 16'sh0000, 16'sh8000, 16'hC000, 1'b1);
    queue_push(16'sh0001, 16'shFFFF, 16'sh0000, 16'hFFFF, 1'b1);
    queue_push(16'sh4000, 16'sh4000, 16'shC000, 16'h2000, 1'b0);
    queue_read(6'd0);
    queue_read(6'd1);
    queue_read(6'd4);
    queue_read(6'd63);
    queue_push(16'sh7FFF, 16'sh0000, 16'sh0000, 16'h1234, 1'b1);
    queue_item(rand_item(CMD_START));
    queue_push(16'sh8000, 16'sh0000, 16'sh0000, 16'hFFFF, 1'b1);
    queue_push(16'sh8000, 16'sh7FFF, 16'sh0000, 16'h0001, 1'b1);
    queue_item(rand_item(CMD_RSVD));
    queue_read(6'd0);
    queue_read(6'd1);
    wait_drained();

    // random phases over a spread of lag limits and torsion settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MAX_LAG, MAX_LAG_W'(lag_plan[ph]));
      write_reg(REG_TORSION, MAX_LAG_W'(tors_plan[ph]));
      steady = (ph % 3 == 2);
      queue_phase(120);
      for (int s = 0; s < 64; s += 9) queue_read(6'(s));
      queue_read(6'd63);
      wait_drained();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
